[rtl/core/tga_pkg.sv]
// Shared types and constants for the TGA run-length pixel decoder.
`timescale 1ns / 1ps

package tga_pkg;

   // Header layout (byte offsets within the 18-byte header)
   localparam logic [4:0] HDR_ID_LEN    = 5'd0;
   localparam logic [4:0] HDR_TYPE      = 5'd2;
   localparam logic [4:0] HDR_WIDTH_LO  = 5'd12;
   localparam logic [4:0] HDR_WIDTH_HI  = 5'd13;
   localparam logic [4:0] HDR_HEIGHT_LO = 5'd14;
   localparam logic [4:0] HDR_HEIGHT_HI = 5'd15;
   localparam logic [4:0] HDR_DEPTH     = 5'd16;
   localparam logic [4:0] HDR_LAST      = 5'd17;

   // Accepted image types and pixel depths
   localparam logic [7:0] TYPE_RAW = 8'd2;
   localparam logic [7:0] TYPE_RLE = 8'd10;
   localparam logic [7:0] DEPTH_24 = 8'd24;
   localparam logic [7:0] DEPTH_32 = 8'd32;

   // Packet header fields
   localparam logic [7:0] PKT_RUN_BIT   = 8'h80;
   localparam logic [7:0] PKT_COUNT_MSK = 8'h7f;

   // Result kinds
   localparam logic [1:0] KIND_HEADER = 2'd0;
   localparam logic [1:0] KIND_PIXEL  = 2'd1;
   localparam logic [1:0] KIND_ERROR  = 2'd2;

   // Error codes
   localparam logic [1:0] ERR_TYPE  = 2'd0;
   localparam logic [1:0] ERR_DEPTH = 2'd1;
   localparam logic [1:0] ERR_TRUNC = 2'd2;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_of_file;
   } req_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
      logic [7:0]  alpha;
      logic [7:0]  repeat_count;
      logic [15:0] image_width;
      logic [15:0] image_height;
      logic        has_alpha;
      logic [1:0]  error_code;
      logic        last;
   } rsp_type;

endpackage

[rtl/core/tga_rle_pixel_decoder.sv]
// Top level of the TGA run-length pixel decoder: byte parser and output buffer.
`timescale 1ns / 1ps

// Takes a TGA file one byte per request and gives at most one result per byte:
// header info on the 18th header byte, then one pixel run per run-length packet
// or per raw pixel, with the stored blue/green/red/alpha bytes returned in
// RGB(A) fields, or an error. The parser state is updated when the byte is
// accepted, and its result is registered in the result register, or in the
// skid register while the output is stalled. The rate is one byte per cycle;
// a two-entry output buffer (result register plus skid register) lets the
// input keep flowing while one result waits, and req_stall rises only while
// both entries are full. A byte marked end_of_file returns the parser to its
// reset state, so the next byte starts a new file.
module tga_rle_pixel_decoder (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  tga_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output tga_pkg::rsp_type rsp_data
);
   import tga_pkg::*;

   typedef enum logic [2:0] {
      PH_HEADER,
      PH_SKIP,
      PH_PACKET,
      PH_PIXEL,
      PH_HALT
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [4:0]  header_index_ff, header_index_in;
   logic [7:0]  id_length_ff, id_length_in;
   logic [7:0]  image_type_ff, image_type_in;
   logic [7:0]  pixel_bits_ff, pixel_bits_in;
   logic [15:0] width_ff, width_in;
   logic [15:0] height_ff, height_in;
   logic [31:0] pixels_left_ff, pixels_left_in;
   logic [7:0]  packet_left_ff, packet_left_in;
   logic        packet_is_run_ff, packet_is_run_in;
   logic [1:0]  byte_in_pixel_ff, byte_in_pixel_in;
   logic [31:0] pixel_collect_ff, pixel_collect_in;

   logic        rsp_valid_ff;
   rsp_type     rsp_data_ff;
   logic        skid_valid_ff;
   rsp_type     skid_data_ff;

   logic        accept;
   logic        rsp_free;
   logic        res_valid;
   rsp_type     res;
   logic [7:0]  b;
   logic [31:0] area;
   logic [31:0] collect_new;
   logic [1:0]  depth_last;
   logic        is_rle;
   logic        is_run;
   logic        done;
   logic [7:0]  count;

   assign accept   = req_valid && !req_stall;
   assign rsp_free = !rsp_valid_ff || !rsp_stall;
   assign b        = req_data.data_byte;
   assign area     = 32'(width_ff) * 32'(height_ff);
   assign is_rle   = (image_type_ff == TYPE_RLE);
   assign is_run   = is_rle && packet_is_run_ff;
   assign depth_last = (pixel_bits_ff == DEPTH_32) ? 2'd3 : 2'd2;

   // Merge the current byte into the pixel being collected
   always_comb begin
      collect_new = pixel_collect_ff;
      collect_new[{byte_in_pixel_ff, 3'b000} +: 8] =
         pixel_collect_ff[{byte_in_pixel_ff, 3'b000} +: 8] | b;
   end

   // Clip a run to the pixels still due; last pixel when nothing remains after it
   always_comb begin
      if (is_run) begin
         done  = (pixels_left_ff <= 32'(packet_left_ff));
         count = done ? pixels_left_ff[7:0] : packet_left_ff;
      end else begin
         done  = (pixels_left_ff == 32'd1);
         count = 8'd1;
      end
   end

   // Parser next state and result for the byte at the input
   always_comb begin
      phase_in         = phase_ff;
      header_index_in  = header_index_ff;
      id_length_in     = id_length_ff;
      image_type_in    = image_type_ff;
      pixel_bits_in    = pixel_bits_ff;
      width_in         = width_ff;
      height_in        = height_ff;
      pixels_left_in   = pixels_left_ff;
      packet_left_in   = packet_left_ff;
      packet_is_run_in = packet_is_run_ff;
      byte_in_pixel_in = byte_in_pixel_ff;
      pixel_collect_in = pixel_collect_ff;
      res_valid        = 1'b0;
      res              = '0;

      unique case (phase_ff)
         PH_HEADER: begin
            // capture the header fields we care about
            unique case (header_index_ff)
               HDR_ID_LEN:    id_length_in = b;
               HDR_TYPE:      image_type_in = b;
               HDR_WIDTH_LO:  width_in[7:0] = b;
               HDR_WIDTH_HI:  width_in[15:8] = b;
               HDR_HEIGHT_LO: height_in[7:0] = b;
               HDR_HEIGHT_HI: height_in[15:8] = b;
               HDR_DEPTH:     pixel_bits_in = b;
               default: ;
            endcase
            header_index_in = header_index_ff + 5'd1;
            if (header_index_ff == HDR_LAST) begin
               header_index_in = '0;
               res_valid       = 1'b1;
               res.last        = 1'b1;
               priority if (image_type_ff != TYPE_RAW && image_type_ff != TYPE_RLE) begin
                  res.kind       = KIND_ERROR;
                  res.error_code = ERR_TYPE;
                  phase_in       = PH_HALT;
               end else if (pixel_bits_ff != DEPTH_24 && pixel_bits_ff != DEPTH_32) begin
                  res.kind       = KIND_ERROR;
                  res.error_code = ERR_DEPTH;
                  phase_in       = PH_HALT;
               end else begin
                  res.kind         = KIND_HEADER;
                  res.image_width  = width_ff;
                  res.image_height = height_ff;
                  res.has_alpha    = (pixel_bits_ff == DEPTH_32);
                  res.last         = (area == 32'd0);
                  pixels_left_in   = area;
                  priority if (area == 32'd0) begin
                     phase_in = PH_HALT;
                  end else if (id_length_ff != 8'd0) begin
                     phase_in = PH_SKIP;
                  end else begin
                     byte_in_pixel_in = '0;
                     pixel_collect_in = '0;
                     phase_in         = is_rle ? PH_PACKET : PH_PIXEL;
                  end
               end
            end
         end
         PH_SKIP: begin
            // drop the image ID field
            id_length_in = id_length_ff - 8'd1;
            if (id_length_ff == 8'd1) begin
               byte_in_pixel_in = '0;
               pixel_collect_in = '0;
               phase_in         = is_rle ? PH_PACKET : PH_PIXEL;
            end
         end
         PH_PACKET: begin
            packet_is_run_in = ((b & PKT_RUN_BIT) != 8'd0);
            packet_left_in   = (b & PKT_COUNT_MSK) + 8'd1;
            byte_in_pixel_in = '0;
            pixel_collect_in = '0;
            phase_in         = PH_PIXEL;
         end
         PH_PIXEL: begin
            if (byte_in_pixel_ff >= depth_last) begin
               // pixel complete: emit a run and advance the counters
               pixels_left_in = pixels_left_ff - 32'(count);
               if (is_rle) begin
                  if (packet_is_run_ff) begin
                     packet_left_in = '0;
                     phase_in       = PH_PACKET;
                  end else begin
                     packet_left_in = packet_left_ff - 8'd1;
                     if (packet_left_ff == 8'd1) begin
                        phase_in = PH_PACKET;
                     end
                  end
               end
               res_valid         = 1'b1;
               res.kind          = KIND_PIXEL;
               res.blue          = collect_new[7:0];
               res.green         = collect_new[15:8];
               res.red           = collect_new[23:16];
               res.alpha         = collect_new[31:24];
               res.repeat_count  = count;
               res.last          = done;
               byte_in_pixel_in  = '0;
               pixel_collect_in  = '0;
               if (done) begin
                  phase_in = PH_HALT;
               end
            end else begin
               byte_in_pixel_in = byte_in_pixel_ff + 2'd1;
               pixel_collect_in = collect_new;
            end
         end
         PH_HALT: ;
         default: ;
      endcase

      // End of file: flag an unfinished image, then return to reset state
      if (req_data.end_of_file) begin
         if (phase_in != PH_HALT) begin
            res_valid      = 1'b1;
            res            = '0;
            res.kind       = KIND_ERROR;
            res.error_code = ERR_TRUNC;
            res.last       = 1'b1;
         end
         phase_in         = PH_HEADER;
         header_index_in  = '0;
         id_length_in     = '0;
         image_type_in    = '0;
         pixel_bits_in    = '0;
         width_in         = '0;
         height_in        = '0;
         pixels_left_in   = '0;
         packet_left_in   = '0;
         packet_is_run_in = 1'b0;
         byte_in_pixel_in = '0;
         pixel_collect_in = '0;
      end
   end

   // Hold parser state; advance on each accepted request
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= PH_HEADER;
         header_index_ff  <= '0;
         id_length_ff     <= '0;
         image_type_ff    <= '0;
         pixel_bits_ff    <= '0;
         width_ff         <= '0;
         height_ff        <= '0;
         pixels_left_ff   <= '0;
         packet_left_ff   <= '0;
         packet_is_run_ff <= 1'b0;
         byte_in_pixel_ff <= '0;
         pixel_collect_ff <= '0;
      end else if (accept) begin
         phase_ff         <= phase_in;
         header_index_ff  <= header_index_in;
         id_length_ff     <= id_length_in;
         image_type_ff    <= image_type_in;
         pixel_bits_ff    <= pixel_bits_in;
         width_ff         <= width_in;
         height_ff        <= height_in;
         pixels_left_ff   <= pixels_left_in;
         packet_left_ff   <= packet_left_in;
         packet_is_run_ff <= packet_is_run_in;
         byte_in_pixel_ff <= byte_in_pixel_in;
         pixel_collect_ff <= pixel_collect_in;
      end
   end

   // Output register with a skid entry behind it
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (rsp_free) begin
         if (skid_valid_ff) begin
            rsp_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            rsp_valid_ff <= accept && res_valid;
         end
      end else if (accept && res_valid) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_free) begin
         if (skid_valid_ff) begin
            rsp_data_ff <= skid_data_ff;
         end else if (accept && res_valid) begin
            rsp_data_ff <= res;
         end
      end else if (accept && res_valid) begin
         skid_data_ff <= res;
      end
   end

   assign req_stall = skid_valid_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Checks on buffer and parser bookkeeping
   a_skid_behind_rsp: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_valid_ff)
      else $error("skid entry full while result register empty");

   a_eof_resets: assert property (@(posedge clock) disable iff (reset)
      accept && req_data.end_of_file |=> phase_ff == PH_HEADER && header_index_ff == 5'd0)
      else $error("parser not back at header start after end of file");

   a_pixels_due: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_PIXEL |-> pixels_left_ff != 32'd0)
      else $error("collecting a pixel with no pixels due");

   a_error_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.kind == KIND_ERROR |-> rsp_data_ff.last)
      else $error("error result without last");

   a_stalled_result_to_skid: assert property (@(posedge clock) disable iff (reset)
      accept && res_valid && !rsp_free |=> skid_valid_ff)
      else $error("result produced under stall was not kept");

endmodule

[tb/sv/tga_rle_pixel_decoder_tb.sv]
// Testbench for the TGA run-length pixel decoder: file byte stimulus, parser predictor, checks.
`timescale 1ns / 1ps

module tga_rle_pixel_decoder_tb;
   import tga_pkg::*;

   localparam int CYCLE_LIMIT = 400000;

   typedef enum logic [2:0] {
      ST_HEADER,
      ST_SKIP_ID,
      ST_PACKET,
      ST_PIXEL,
      ST_HALTED
   } parse_state_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   // knobs shared between the test tasks and the driver processes
   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int hold_req       = 0;
   int hold_cnt       = 0;
   int sent_count     = 0;
   int fail_count     = 0;
   int cycle_count    = 0;

   rsp_type    expected_q[$];
   logic [7:0] file_q[$];

   // parser state mirrored by the predictor
   parse_state_type st;
   logic [4:0]   hdr_idx;
   logic [7:0]   id_left;
   logic [7:0]   img_type;
   logic [7:0]   px_bits;
   logic [15:0]  img_w;
   logic [15:0]  img_h;
   logic [31:0]  px_left;
   logic [7:0]   pkt_left;
   logic         pkt_run;
   logic [1:0]   px_byte;
   logic [31:0]  px_acc;

   tga_rle_pixel_decoder i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tga_rle_pixel_decoder_tb failed");
         $finish;
      end
   end

   // Drive result stall: long hold-off on request, else random
   always @(negedge clock) begin
      if (hold_req > 0) begin
         hold_cnt = hold_req;
         hold_req = 0;
      end
      if (hold_cnt > 0) begin
         hold_cnt--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < recv_stall_pct);
      end
   end

   function automatic rsp_type make_result(logic [1:0] kind, logic [31:0] px,
                                           logic [7:0] count, logic [15:0] w,
                                           logic [15:0] h, logic ha,
                                           logic [1:0] err, logic last);
      rsp_type r;
      r.kind         = kind;
      r.red          = px[23:16];
      r.green        = px[15:8];
      r.blue         = px[7:0];
      r.alpha        = px[31:24];
      r.repeat_count = count;
      r.image_width  = w;
      r.image_height = h;
      r.has_alpha    = ha;
      r.error_code   = err;
      r.last         = last;
      return r;
   endfunction

   function void reset_parser();
      st       = ST_HEADER;
      hdr_idx  = '0;
      id_left  = '0;
      img_type = '0;
      px_bits  = '0;
      img_w    = '0;
      img_h    = '0;
      px_left  = '0;
      pkt_left = '0;
      pkt_run  = 1'b0;
      px_byte  = '0;
      px_acc   = '0;
   endfunction

   function void start_data();
      px_byte = '0;
      px_acc  = '0;
      st      = (img_type == TYPE_RLE) ? ST_PACKET : ST_PIXEL;
   endfunction

   // Advance the parser by one file byte and queue the result it causes
   function void decode_byte(logic [7:0] b, logic eof);
      rsp_type     res;
      bit          have;
      logic [31:0] run_len;
      logic [1:0]  px_top;
      have = 0;
      unique case (st)
         ST_HEADER: begin
            unique case (hdr_idx)
               HDR_ID_LEN:    id_left = b;
               HDR_TYPE:      img_type = b;
               HDR_WIDTH_LO:  img_w[7:0] = b;
               HDR_WIDTH_HI:  img_w[15:8] = b;
               HDR_HEIGHT_LO: img_h[7:0] = b;
               HDR_HEIGHT_HI: img_h[15:8] = b;
               HDR_DEPTH:     px_bits = b;
               default: ;
            endcase
            if (hdr_idx == HDR_LAST) begin
               hdr_idx = '0;
               have = 1;
               if (img_type != TYPE_RAW && img_type != TYPE_RLE) begin
                  res = make_result(KIND_ERROR, 0, 0, 0, 0, 0, ERR_TYPE, 1'b1);
                  st = ST_HALTED;
               end else if (px_bits != DEPTH_24 && px_bits != DEPTH_32) begin
                  res = make_result(KIND_ERROR, 0, 0, 0, 0, 0, ERR_DEPTH, 1'b1);
                  st = ST_HALTED;
               end else begin
                  px_left = {16'b0, img_w} * {16'b0, img_h};
                  res = make_result(KIND_HEADER, 0, 0, img_w, img_h,
                                    px_bits == DEPTH_32, '0, px_left == 0);
                  if (px_left == 0) st = ST_HALTED;
                  else if (id_left != 0) st = ST_SKIP_ID;
                  else start_data();
               end
            end else begin
               hdr_idx = hdr_idx + 5'd1;
            end
         end
         ST_SKIP_ID: begin
            id_left = id_left - 8'd1;
            if (id_left == 0) start_data();
         end
         ST_PACKET: begin
            pkt_run  = (b & PKT_RUN_BIT) != 0;
            pkt_left = (b & PKT_COUNT_MSK) + 8'd1;
            px_byte  = '0;
            px_acc   = '0;
            st       = ST_PIXEL;
         end
         ST_PIXEL: begin
            px_top = (px_bits == DEPTH_32) ? 2'd3 : 2'd2;
            px_acc = px_acc | (32'(b) << (8 * px_byte));
            if (px_byte >= px_top) begin
               run_len = 1;
               if (img_type == TYPE_RLE && pkt_run) begin
                  run_len = 32'(pkt_left);
                  if (run_len > px_left) run_len = px_left;
               end
               px_left = px_left - run_len;
               if (img_type == TYPE_RLE) begin
                  if (pkt_run) pkt_left = '0;
                  else pkt_left = pkt_left - 8'd1;
                  if (pkt_left == 0) st = ST_PACKET;
               end
               res = make_result(KIND_PIXEL, px_acc, run_len[7:0], 0, 0, 0, '0,
                                 px_left == 0);
               have = 1;
               px_byte = '0;
               px_acc  = '0;
               if (px_left == 0) st = ST_HALTED;
            end else begin
               px_byte = px_byte + 2'd1;
            end
         end
         default: ;
      endcase
      // end of file replaces any result with a truncation error if unfinished
      if (eof) begin
         if (st != ST_HALTED) begin
            res = make_result(KIND_ERROR, 0, 0, 0, 0, 0, ERR_TRUNC, 1'b1);
            have = 1;
         end
         reset_parser();
      end
      if (have) expected_q.push_back(res);
   endfunction

   function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         fail_count++;
      end
   endfunction

   // Check each accepted result against the oldest expectation
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_q.size() == 0) begin
            $error("result with no expectation: kind %0h", rsp_data.kind);
            fail_count++;
         end else begin
            want = expected_q.pop_front();
            compare_field("kind", 32'(want.kind), 32'(rsp_data.kind));
            compare_field("red", 32'(want.red), 32'(rsp_data.red));
            compare_field("green", 32'(want.green), 32'(rsp_data.green));
            compare_field("blue", 32'(want.blue), 32'(rsp_data.blue));
            compare_field("alpha", 32'(want.alpha), 32'(rsp_data.alpha));
            compare_field("repeat_count", 32'(want.repeat_count),
                          32'(rsp_data.repeat_count));
            compare_field("image_width", 32'(want.image_width),
                          32'(rsp_data.image_width));
            compare_field("image_height", 32'(want.image_height),
                          32'(rsp_data.image_height));
            compare_field("has_alpha", 32'(want.has_alpha), 32'(rsp_data.has_alpha));
            compare_field("error_code", 32'(want.error_code), 32'(rsp_data.error_code));
            compare_field("last", 32'(want.last), 32'(rsp_data.last));
         end
      end
   end

   // File building: append bytes to the pending file
   function void add_noise(int n);
      for (int i = 0; i < n; i++) file_q.push_back(8'($urandom));
   endfunction

   function void add_header(logic [7:0] id_len, logic [7:0] img_t, logic [15:0] w,
                            logic [15:0] h, logic [7:0] bits);
      logic [7:0] hdr [0:17];
      for (int i = 0; i < 18; i++) hdr[i] = 8'($urandom);
      hdr[HDR_ID_LEN]    = id_len;
      hdr[HDR_TYPE]      = img_t;
      hdr[HDR_WIDTH_LO]  = w[7:0];
      hdr[HDR_WIDTH_HI]  = w[15:8];
      hdr[HDR_HEIGHT_LO] = h[7:0];
      hdr[HDR_HEIGHT_HI] = h[15:8];
      hdr[HDR_DEPTH]     = bits;
      for (int i = 0; i < 18; i++) file_q.push_back(hdr[i]);
      add_noise(id_len);
   endfunction

   // Mix run and raw packets; the last packet may run past the image end
   function void add_rle_data(int npix, int bpp);
      int left;
      int cnt;
      left = npix;
      while (left > 0) begin
         if ($urandom_range(0, 1)) begin
            cnt = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 128) : $urandom_range(1, 6);
            file_q.push_back(PKT_RUN_BIT | 8'(cnt - 1));
            add_noise(bpp);
         end else begin
            cnt = $urandom_range(1, 6);
            file_q.push_back(8'(cnt - 1));
            add_noise(cnt * bpp);
         end
         left -= cnt;
      end
   endfunction

   // Send one request; called and returning at a falling edge
   task automatic send_byte(logic [7:0] b, logic eof);
      req_type r;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      r.data_byte   = b;
      r.end_of_file = eof;
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (req_stall);
      decode_byte(b, eof);
      sent_count++;
      @(negedge clock);
   endtask

   task automatic send_range(int first_i, int end_i, bit eof_at_end);
      for (int i = first_i; i < end_i; i++)
         send_byte(file_q[i], eof_at_end && (i == end_i - 1));
   endtask

   // Send the pending file, dropping its last bytes to truncate it
   task automatic send_file(int cut);
      int n;
      n = file_q.size() - cut;
      if (n < 1) n = 1;
      send_range(0, n, 1'b1);
      file_q.delete();
   endtask

   task automatic wait_drain();
      req_valid <= 1'b0;
      while (expected_q.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic test_bad_header();
      add_header(0, 8'd3, 2, 2, DEPTH_24);
      add_noise(4);
      send_file(0);
      add_header(0, TYPE_RLE, 2, 2, 8'd16);
      send_file(0);
      // bad type wins over bad depth
      add_header(0, 8'hFF, 1, 1, 8'd8);
      add_noise(2);
      send_file(0);
   endtask

   task automatic test_empty_image();
      add_header(2, TYPE_RAW, 16'hFFFF, 16'h0000, DEPTH_32);
      add_noise(3);
      send_file(0);
      add_header(0, TYPE_RLE, 16'h0000, 16'hFFFF, DEPTH_24);
      send_file(0);
   endtask

   task automatic test_raw_image();
      add_header(3, TYPE_RAW, 2, 2, DEPTH_24);
      add_noise(12 + 2);
      send_file(0);
      add_header(0, TYPE_RAW, 3, 1, DEPTH_32);
      repeat (4) file_q.push_back(8'hFF);
      repeat (4) file_q.push_back(8'h00);
      add_noise(4);
      send_file(0);
      add_header(8'd20, TYPE_RAW, 1, 1, DEPTH_24);
      add_noise(3);
      send_file(0);
   endtask

   task automatic test_rle_image();
      add_header(0, TYPE_RLE, 3, 2, DEPTH_32);
      file_q.push_back(PKT_RUN_BIT | 8'd3);
      add_noise(4);
      file_q.push_back(8'd1);
      add_noise(8);
      send_file(0);
      // clip an overlong run
      add_header(1, TYPE_RLE, 2, 1, DEPTH_24);
      file_q.push_back(PKT_RUN_BIT | PKT_COUNT_MSK);
      add_noise(3 + 3);
      send_file(0);
      // drop raw pixels past the image end
      add_header(0, TYPE_RLE, 1, 1, DEPTH_24);
      file_q.push_back(8'd2);
      add_noise(9);
      send_file(0);
   endtask

   task automatic test_truncation();
      add_header(0, TYPE_RAW, 2, 2, DEPTH_24);
      send_file(13);
      // end of file on the last header byte replaces the header info
      add_header(0, TYPE_RLE, 1, 1, DEPTH_24);
      file_q.push_back(8'd0);
      add_noise(3);
      send_file(4);
      add_header(0, TYPE_RAW, 16'hFFFF, 16'hFFFF, DEPTH_32);
      add_noise(10);
      send_file(0);
      add_header(3, TYPE_RAW, 1, 1, DEPTH_24);
      send_file(1);
      add_noise(1);
      send_file(0);
   endtask

   // Stall results for a long stretch while the input keeps coming
   task automatic test_long_holdoff();
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      hold_req = 300;
      add_header(0, TYPE_RAW, 4, 2, DEPTH_24);
      add_noise(24);
      send_file(0);
   endtask

   // Pause mid-file until every expected result has come
   task automatic test_drain_pause();
      add_header(2, TYPE_RLE, 4, 4, DEPTH_32);
      add_rle_data(16, 4);
      send_range(0, 20, 1'b0);
      wait_drain();
      send_range(20, file_q.size(), 1'b1);
      file_q.delete();
   endtask

   task automatic random_file();
      int         r;
      int         w;
      int         h;
      int         bpp;
      int         cut;
      logic [7:0] ty;
      logic [7:0] bits;
      r = $urandom_range(0, 99);
      cut = 0;
      if (r < 72) begin
         ty   = $urandom_range(0, 1) ? TYPE_RLE : TYPE_RAW;
         bits = $urandom_range(0, 1) ? DEPTH_32 : DEPTH_24;
         bpp  = (bits == DEPTH_32) ? 4 : 3;
         w    = ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 4);
         h    = $urandom_range(1, 4);
         add_header(8'(($urandom_range(0, 9) < 7) ? 0 : $urandom_range(1, 4)), ty,
                    16'(w), 16'(h), bits);
         if (ty == TYPE_RLE) add_rle_data(w * h, bpp);
         else add_noise(w * h * bpp);
         if ($urandom_range(0, 3) == 0) add_noise($urandom_range(1, 4));
         if ($urandom_range(0, 6) == 0) cut = $urandom_range(1, file_q.size() - 1);
      end else if (r < 86) begin
         add_header(8'($urandom_range(0, 2)), 8'($urandom), 16'($urandom), 16'($urandom),
                    8'($urandom));
         add_noise($urandom_range(0, 4));
      end else begin
         add_noise($urandom_range(1, 24));
      end
      send_file(cut);
   endtask

   task automatic test_random(int send_pct, int recv_pct, int n_bytes);
      int start;
      send_idle_pct  = send_pct;
      recv_stall_pct = recv_pct;
      start = sent_count;
      while (sent_count - start < n_bytes) random_file();
   endtask

   initial begin
      req_valid = 1'b0;
      req_data  = '0;
      reset_parser();
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_bad_header();
      test_empty_image();
      test_raw_image();
      test_rle_image();
      test_truncation();
      test_long_holdoff();
      test_drain_pause();
      test_random(0, 0, 25);
      test_random(47, 0, 25);
      test_random(0, 47, 25);
      test_random(29, 29, 25);

      // let the last results out, then report
      wait_drain();
      repeat (8) @(negedge clock);
      if (fail_count == 0) begin
         $display("tga_rle_pixel_decoder_tb passed");
      end else begin
         $display("tga_rle_pixel_decoder_tb failed");
      end
      $finish;
   end

endmodule

[files.f]
rtl/core/tga_pkg.sv
rtl/core/tga_rle_pixel_decoder.sv
tb/sv/tga_rle_pixel_decoder_tb.sv
